// ----- rtl/core/aaes_pkg.sv -----
package aaes_pkg;

  localparam int COORD_W   = 16;
  localparam int DIAM_W    = 12;
  localparam int COL_W     = 17;
  localparam int ROW_W     = 22;
  localparam int STEP_Y_W  = 21;
  localparam int ERR_W     = 48;
  localparam int ERR_EXT_W = 50;
  localparam int ASPECT_W  = 8;
  localparam int SQ_W      = 16;
  localparam int SLOTS     = 4;
  localparam int SLOT_IDX_W = 2;
  localparam int KIND_W    = 2;
  localparam int OUT_FIELDS_W = COL_W + COL_W + ROW_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOT  = 2'd0,
    KIND_SPAN = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [COL_W-1:0]  left_x;
    logic signed [COL_W-1:0]  right_x;
    logic signed [ROW_W-1:0]  row_y;
  } res_t;

  typedef struct packed {
    res_t [SLOTS-1:0]        slot;
    logic [SLOT_IDX_W-1:0]   last_idx;
    logic                    done;
  } bundle_t;

endpackage

// ----- rtl/core/aaes_core.sv -----
module aaes_core
  import aaes_pkg::*;
#(
  parameter int MAX_DIAMETER_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  op_e                          opcode_i,
  input  logic signed [COORD_W-1:0]    center_x_i,
  input  logic signed [COORD_W-1:0]    center_y_i,
  input  logic [MAX_DIAMETER_BITS-1:0] diameter_i,
  input  logic [ASPECT_W-1:0]          aspect_x_i,
  input  logic [ASPECT_W-1:0]          aspect_y_i,
  input  logic                         fill_i,
  output bundle_t                      bundle_o
);

  localparam int XW = MAX_DIAMETER_BITS - 1;
  localparam int XPW = XW + 19;
  localparam int YPW = SQ_W + STEP_Y_W + 1;

  logic [XW-1:0]              step_x_q, step_x_d;
  logic [STEP_Y_W-1:0]        step_y_q, step_y_d;
  logic signed [ERR_W-1:0]    err_q, err_d;
  logic [STEP_Y_W-1:0]        prev_row_q, prev_row_d;
  logic                       even_q, even_d;
  logic                       filled_q, filled_d;
  logic signed [COORD_W-1:0]  org_x_q, org_x_d;
  logic signed [COORD_W-1:0]  org_y_q, org_y_d;
  logic [SQ_W-1:0]            sqx_q, sqx_d;
  logic [SQ_W-1:0]            sqy_q, sqy_d;
  logic                       active_q, active_d;

  logic signed [XW+1:0]          x_coef;
  logic signed [XPW-1:0]         x_prod;
  logic [YPW-1:0]                y_prod;
  logic signed [ERR_EXT_W-1:0]   err_w, xt_w, yt_w, xerr, yerr, derr;
  logic [ERR_EXT_W-1:0]          ad, ay, ax;
  logic                          mv_diag, mv_vert, dec_x, inc_y;
  logic [XW-1:0]                 nx;
  logic [STEP_Y_W-1:0]           ny;
  logic signed [ERR_W-1:0]       nerr;

  logic signed [COL_W-1:0]   cx_w, nx_w, ev_col, col_l, col_r;
  logic signed [ROW_W:0]     cy_w, ny_w, ev_row, row_lo_w, row_hi_w;
  logic signed [ROW_W-1:0]   row_lo, row_hi;

  logic [XW-1:0]             x0;
  logic signed [COL_W-1:0]   cx_in, x0_w, st_l, st_r;
  logic signed [ROW_W-1:0]   st_row;
  logic                      d_even, d_zero, x0_zero;

  assign x_coef = $signed({{(XW + 1){1'b0}}, 1'b1}) - $signed({1'b0, step_x_q, 1'b0});
  assign x_prod = XPW'($signed({1'b0, sqy_q})) * XPW'(x_coef);
  assign y_prod = YPW'(sqx_q) * YPW'({step_y_q, 1'b1});

  assign err_w = ERR_EXT_W'(err_q);
  assign xt_w  = ERR_EXT_W'(x_prod);
  assign yt_w  = $signed({{(ERR_EXT_W - YPW){1'b0}}, y_prod});
  assign xerr  = err_w + xt_w;
  assign yerr  = err_w + yt_w;
  assign derr  = xerr + yt_w;

  assign ad = derr[ERR_EXT_W-1] ? -derr : derr;
  assign ay = yerr[ERR_EXT_W-1] ? -yerr : yerr;
  assign ax = xerr[ERR_EXT_W-1] ? -xerr : xerr;

  assign mv_diag = (ad <= ay) && (ad <= ax);
  assign mv_vert = !mv_diag && (ay <= ax);
  assign dec_x   = !mv_vert;
  assign inc_y   = mv_diag || mv_vert;

  assign nx   = step_x_q - XW'(dec_x);
  assign ny   = step_y_q + STEP_Y_W'(inc_y);
  assign nerr = mv_diag ? derr[ERR_W-1:0] : (mv_vert ? yerr[ERR_W-1:0] : xerr[ERR_W-1:0]);

  assign cx_w   = COL_W'(org_x_q);
  assign nx_w   = $signed({{(COL_W - XW){1'b0}}, nx});
  assign ev_col = $signed({{(COL_W - 1){1'b0}}, even_q});
  assign col_l  = cx_w - nx_w;
  assign col_r  = cx_w + nx_w - ev_col;

  assign cy_w     = (ROW_W + 1)'(org_y_q);
  assign ny_w     = $signed({2'b00, ny});
  assign ev_row   = $signed({{ROW_W{1'b0}}, even_q});
  assign row_lo_w = cy_w - ny_w;
  assign row_hi_w = cy_w + ny_w - ev_row;
  assign row_lo   = row_lo_w[ROW_W-1:0];
  assign row_hi   = row_hi_w[ROW_W-1:0];

  assign x0      = diameter_i[MAX_DIAMETER_BITS-1:1];
  assign cx_in   = COL_W'(center_x_i);
  assign x0_w    = $signed({{(COL_W - XW){1'b0}}, x0});
  assign st_l    = cx_in - x0_w;
  assign st_r    = cx_in + x0_w;
  assign st_row  = ROW_W'(center_y_i);
  assign d_even  = !diameter_i[0];
  assign d_zero  = (diameter_i == '0);
  assign x0_zero = (x0 == '0);

  always_comb begin
    step_x_d   = step_x_q;
    step_y_d   = step_y_q;
    err_d      = err_q;
    prev_row_d = prev_row_q;
    even_d     = even_q;
    filled_d   = filled_q;
    org_x_d    = org_x_q;
    org_y_d    = org_y_q;
    sqx_d      = sqx_q;
    sqy_d      = sqy_q;
    active_d   = active_q;
    for (int i = 0; i < SLOTS; i++) begin
      bundle_o.slot[i] = '{kind: KIND_NONE, left_x: '0, right_x: '0, row_y: '0};
    end
    bundle_o.last_idx = '0;

    if (opcode_i == OP_START) begin
      org_x_d    = center_x_i;
      org_y_d    = center_y_i;
      sqx_d      = SQ_W'(aspect_x_i) * SQ_W'(aspect_x_i);
      sqy_d      = SQ_W'(aspect_y_i) * SQ_W'(aspect_y_i);
      filled_d   = fill_i;
      err_d      = '0;
      even_d     = d_even;
      step_x_d   = x0;
      step_y_d   = '0;
      prev_row_d = '0;
      active_d   = 1'b1;
      if (!d_even || d_zero) begin
        if (fill_i) begin
          bundle_o.slot[0] = '{kind: KIND_SPAN, left_x: st_l, right_x: st_r, row_y: st_row};
        end else begin
          bundle_o.slot[0] = '{kind: KIND_DOT, left_x: st_l, right_x: st_l, row_y: st_row};
          if (!x0_zero) begin
            bundle_o.slot[1] = '{kind: KIND_DOT, left_x: st_r, right_x: st_r, row_y: st_row};
            bundle_o.last_idx = SLOT_IDX_W'(1);
          end
        end
        if (x0_zero) begin
          active_d = 1'b0;
        end
      end
    end else if (active_q) begin
      step_x_d = nx;
      step_y_d = ny;
      err_d    = nerr;
      if (filled_q) begin
        if (prev_row_q != ny) begin
          bundle_o.slot[0] = '{kind: KIND_SPAN, left_x: col_l, right_x: col_r, row_y: row_lo};
          bundle_o.slot[1] = '{kind: KIND_SPAN, left_x: col_l, right_x: col_r, row_y: row_hi};
          bundle_o.last_idx = SLOT_IDX_W'(1);
          prev_row_d = ny;
        end
        if (nx == '0) begin
          active_d = 1'b0;
        end
      end else begin
        bundle_o.slot[0] = '{kind: KIND_DOT, left_x: col_r, right_x: col_r, row_y: row_hi};
        bundle_o.slot[1] = '{kind: KIND_DOT, left_x: col_r, right_x: col_r, row_y: row_lo};
        bundle_o.last_idx = SLOT_IDX_W'(1);
        if (!even_q && nx == '0) begin
          active_d = 1'b0;
        end else begin
          bundle_o.slot[2] = '{kind: KIND_DOT, left_x: col_l, right_x: col_l, row_y: row_hi};
          bundle_o.slot[3] = '{kind: KIND_DOT, left_x: col_l, right_x: col_l, row_y: row_lo};
          bundle_o.last_idx = SLOT_IDX_W'(3);
          if (even_q && nx <= XW'(1)) begin
            active_d = 1'b0;
          end
        end
      end
    end
    bundle_o.done = !active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q   <= '0;
      step_y_q   <= '0;
      err_q      <= '0;
      prev_row_q <= '0;
      even_q     <= 1'b0;
      filled_q   <= 1'b0;
      org_x_q    <= '0;
      org_y_q    <= '0;
      sqx_q      <= '0;
      sqy_q      <= '0;
      active_q   <= 1'b0;
    end else if (load_i) begin
      step_x_q   <= step_x_d;
      step_y_q   <= step_y_d;
      err_q      <= err_d;
      prev_row_q <= prev_row_d;
      even_q     <= even_d;
      filled_q   <= filled_d;
      org_x_q    <= org_x_d;
      org_y_q    <= org_y_d;
      sqx_q      <= sqx_d;
      sqy_q      <= sqy_d;
      active_q   <= active_d;
    end
  end

  // A live figure always has a column left to step, so the decrement never wraps.
  a_active_has_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (step_x_q != '0))
    else $error("active figure with zero column count");

  a_done_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (active_q == !$past(bundle_o.done)))
    else $error("figure done flag disagrees with stored state");

endmodule

// ----- rtl/core/aaes_outbuf.sv -----
module aaes_outbuf
  import aaes_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    free_o,
  output logic    tvalid_o,
  input  logic    tready_i,
  output res_t    res_o,
  output logic    last_o,
  output logic    done_o
);

  logic                  valid_q;
  logic [SLOT_IDX_W-1:0] idx_q;
  bundle_t               bundle_q;
  logic                  take;
  logic                  at_last;

  assign take    = valid_q && tready_i;
  assign at_last = (idx_q == bundle_q.last_idx);
  assign free_o  = !valid_q || (take && at_last);

  assign tvalid_o = valid_q;
  assign res_o    = bundle_q.slot[idx_q];
  assign last_o   = at_last;
  assign done_o   = bundle_q.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take && at_last) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + SLOT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= bundle_q.last_idx))
    else $error("result index beyond last result");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("results loaded over undelivered results");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && at_last && !load_i) |=> !valid_q)
    else $error("buffer still valid after last result taken");

endmodule

// ----- rtl/core/axis_aligned_ellipse_stepper.sv -----
// Channel   Direction  Payload (low bit first)
// s_axis    in         tdata: center_x, center_y, diameter_x, aspect_x, aspect_y, fill_mode
//                      tuser: opcode
// m_axis    out        tdata: left_x, right_x, row_y, figure_done; tuser: item_kind
//                      tlast: last_of_step
// Each input transaction produces one to four output transactions, one per cycle while m_axis_tready is high.
// Results per input: 1 for a status item, 1 or 2 for a start, 1 for a filled step on
// the same row, 2 for a filled step on a new row, 2 or 4 for an outline step.
// The four-entry result buffer drains one result a cycle while the output is ready.
// Reset clears the figure state; no figure is active afterward.
// A stalled output holds the buffer, and the input register then holds one item.
module axis_aligned_ellipse_stepper
  import aaes_pkg::*;
#(
  parameter int MAX_DIAMETER_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // center_x[15:0], center_y, diameter_x, aspect_x, aspect_y, fill_mode, zero fill
  input  logic [((2 * COORD_W + DIAM_W + 2 * ASPECT_W + 1 + 7) / 8) * 8 - 1:0]
                                 s_axis_tdata_i,
  // opcode
  input  logic [0:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // left_x[16:0], right_x, row_y, figure_done, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // item_kind
  output logic [KIND_W-1:0]      m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam int DB      = MAX_DIAMETER_BITS;
  localparam int CY_LO   = COORD_W;
  localparam int D_LO    = 2 * COORD_W;
  localparam int AX_LO   = D_LO + DIAM_W;
  localparam int AY_LO   = AX_LO + ASPECT_W;
  localparam int FILL_B  = AY_LO + ASPECT_W;

  logic                       in_valid_q;
  op_e                        op_q;
  logic signed [COORD_W-1:0]  cx_q, cy_q;
  logic [DB-1:0]              diam_q;
  logic [ASPECT_W-1:0]        ax_q, ay_q;
  logic                       fill_q;

  logic    buf_free;
  logic    advance;
  logic    s_take;
  bundle_t bundle;
  res_t    res;
  logic    res_last;
  logic    res_done;

  assign advance         = in_valid_q && buf_free;
  assign s_axis_tready_o = !in_valid_q || buf_free;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      op_q   <= op_e'(s_axis_tuser_i[0]);
      cx_q   <= s_axis_tdata_i[CY_LO-1:0];
      cy_q   <= s_axis_tdata_i[D_LO-1:CY_LO];
      diam_q <= DB'(s_axis_tdata_i[AX_LO-1:D_LO]);
      ax_q   <= s_axis_tdata_i[AY_LO-1:AX_LO];
      ay_q   <= s_axis_tdata_i[FILL_B-1:AY_LO];
      fill_q <= s_axis_tdata_i[FILL_B];
    end
  end

  aaes_core #(
    .MAX_DIAMETER_BITS(MAX_DIAMETER_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .opcode_i   (op_q),
    .center_x_i (cx_q),
    .center_y_i (cy_q),
    .diameter_i (diam_q),
    .aspect_x_i (ax_q),
    .aspect_y_i (ay_q),
    .fill_i     (fill_q),
    .bundle_o   (bundle)
  );

  aaes_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .bundle_i (bundle),
    .free_o   (buf_free),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .res_o    (res),
    .last_o   (res_last),
    .done_o   (res_done)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, res_done, res.row_y,
                           res.right_x, res.left_x};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res_last;

endmodule

// ----- tb/sv/axis_aligned_ellipse_stepper_tb.sv -----
module axis_aligned_ellipse_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aaes_pkg::*;

  localparam int DIA_W        = 12;
  localparam int IN_FIELDS_W  = 2 * COORD_W + DIA_W + 2 * ASPECT_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 300;
  localparam int PLAN_LEN     = 25;

  typedef struct packed {
    kind_e                   kind;
    logic signed [COL_W-1:0] left_x;
    logic signed [COL_W-1:0] right_x;
    logic signed [ROW_W-1:0] row_y;
    logic                    last;
    logic                    done;
  } draw_t;

  typedef struct {
    op_e                 op;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [DIA_W-1:0]    dia;
    logic [ASPECT_W-1:0] ax;
    logic [ASPECT_W-1:0] ay;
    logic                fill;
    bit                  typed;
    draw_t               want;
  } stim_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [IN_TDATA_W-1:0]  in_data   = '0;
  logic [0:0]             in_user   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_data;
  logic [KIND_W-1:0]      out_kind;
  logic                   out_last;

  int          ctr_x;
  int          ctr_y;
  int          run_x;
  logic [STEP_Y_W-1:0] run_y;
  logic [STEP_Y_W-1:0] last_row;
  longint      err_acc;
  longint      sq_x;
  longint      sq_y;
  bit          even_dia;
  bit          filled;
  bit          figure_live;

  draw_t       step_draws[$];
  draw_t       pending_draws[$];
  int          mismatches  = 0;
  int          sent        = 0;
  int          idle_cycles = 0;
  bit          quiet_in    = 1'b0;
  bit          quiet_out   = 1'b0;

  stim_t plan [0:PLAN_LEN-1] = '{
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b1,
      '{KIND_NONE, 0, 0, 0, 1'b1, 1'b1}},
    '{OP_START, 16'h8000, 16'h7FFF, 12'd0,    8'd1,   8'd1,   1'b0, 1'b1,
      '{KIND_DOT, -32768, -32768, 32767, 1'b1, 1'b1}},
    '{OP_STEP,  16'hFFFF, 16'hFFFF, 12'hFFF,  8'hFF,  8'hFF,  1'b1, 1'b1,
      '{KIND_NONE, 0, 0, 0, 1'b1, 1'b1}},
    '{OP_START, 16'h7FFF, 16'h8000, 12'd1,    8'd255, 8'd255, 1'b1, 1'b1,
      '{KIND_SPAN, 32767, 32767, -32768, 1'b1, 1'b1}},
    '{OP_START, 16'h8000, 16'h0000, 12'd4095, 8'd1,   8'd1,   1'b1, 1'b1,
      '{KIND_SPAN, -34815, -30721, 0, 1'b1, 1'b0}},
    '{OP_START, 16'h7FFF, 16'hFFFF, 12'd4095, 8'd255, 8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_START, 16'd100,  16'hFFCE, 12'd6,    8'd3,   8'd2,   1'b0, 1'b1,
      '{KIND_NONE, 0, 0, 0, 1'b1, 1'b0}},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_START, 16'hFFF9, 16'd9,    12'd7,    8'd1,   8'd3,   1'b1, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_START, 16'd0,    16'd0,    12'd5,    8'd2,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_START, 16'd1234, 16'hEF1F, 12'd8,    8'd170, 8'd85,  1'b1, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0},
    '{OP_STEP,  16'h0000, 16'h0000, 12'd0,    8'd1,   8'd1,   1'b0, 1'b0, '0}
  };

  axis_aligned_ellipse_stepper dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_kind),
    .m_axis_tlast_o  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit(kind_e kind, longint lx, longint rx, longint ry);
    draw_t d;
    d.kind    = kind;
    d.left_x  = lx[COL_W-1:0];
    d.right_x = rx[COL_W-1:0];
    d.row_y   = ry[ROW_W-1:0];
    d.last    = 1'b0;
    d.done    = 1'b0;
    step_draws.push_back(d);
  endfunction

  // Computes the dots, spans or status item that one input transaction causes and
  // advances the stepper state.
  function automatic void rasterize(input op_e op,
                                    input logic [COORD_W-1:0] cx_in, cy_in,
                                    input logic [DIA_W-1:0] dia,
                                    input logic [ASPECT_W-1:0] ax, ay,
                                    input logic fill);
    longint x, y, xerr, yerr, derr, dmag, ymag, xmag, ev;
    logic signed [ERR_W-1:0] err_wrapped;
    step_draws.delete();
    if (op == OP_START) begin
      ctr_x       = $signed(cx_in);
      ctr_y       = $signed(cy_in);
      sq_x        = longint'(ax) * longint'(ax);
      sq_y        = longint'(ay) * longint'(ay);
      filled      = fill;
      err_acc     = 0;
      even_dia    = !dia[0];
      run_x       = dia >> 1;
      run_y       = '0;
      last_row    = '0;
      figure_live = 1'b1;
      if (!even_dia || dia == 0) begin
        x = run_x;
        if (filled) begin
          emit(KIND_SPAN, ctr_x - x, ctr_x + x, ctr_y);
        end else begin
          emit(KIND_DOT, ctr_x - x, ctr_x - x, ctr_y);
          if (x > 0) emit(KIND_DOT, ctr_x + x, ctr_x + x, ctr_y);
        end
        if (x <= 0) figure_live = 1'b0;
      end
    end else if (figure_live) begin
      x    = run_x;
      y    = run_y;
      xerr = err_acc + sq_y * (1 - 2 * x);
      yerr = err_acc + sq_x * (2 * y + 1);
      derr = yerr + xerr - err_acc;
      dmag = derr < 0 ? -derr : derr;
      ymag = yerr < 0 ? -yerr : yerr;
      xmag = xerr < 0 ? -xerr : xerr;
      if (dmag <= ymag && dmag <= xmag) begin
        err_acc = derr;
        run_x--;
        run_y++;
      end else if (ymag <= xmag) begin
        err_acc = yerr;
        run_y++;
      end else begin
        err_acc = xerr;
        run_x--;
      end
      err_wrapped = err_acc[ERR_W-1:0];
      err_acc     = err_wrapped;
      x  = run_x;
      y  = run_y;
      ev = even_dia;
      if (filled) begin
        if (last_row != run_y) begin
          emit(KIND_SPAN, ctr_x - x, ctr_x + x - ev, ctr_y - y);
          emit(KIND_SPAN, ctr_x - x, ctr_x + x - ev, ctr_y + y - ev);
          last_row = run_y;
        end
        if (x <= 0) figure_live = 1'b0;
      end else begin
        emit(KIND_DOT, ctr_x + x - ev, ctr_x + x - ev, ctr_y + y - ev);
        emit(KIND_DOT, ctr_x + x - ev, ctr_x + x - ev, ctr_y - y);
        if (even_dia || x > 0) begin
          emit(KIND_DOT, ctr_x - x, ctr_x - x, ctr_y + y - ev);
          emit(KIND_DOT, ctr_x - x, ctr_x - x, ctr_y - y);
          if (even_dia && x <= 1) figure_live = 1'b0;
        end else begin
          figure_live = 1'b0;
        end
      end
    end
    if (step_draws.size() == 0) emit(KIND_NONE, 0, 0, 0);
    foreach (step_draws[i]) step_draws[i].done = !figure_live;
    step_draws[step_draws.size()-1].last = 1'b1;
  endfunction

  task automatic send(input op_e op,
                      input logic [COORD_W-1:0] cx, cy,
                      input logic [DIA_W-1:0] dia,
                      input logic [ASPECT_W-1:0] ax, ay,
                      input logic fill,
                      input bit typed,
                      input draw_t want);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, fill, ay, ax, dia, cy, cx};
    in_user  <= op;
    do @(posedge clk); while (!in_ready);
    rasterize(op, cx, cy, dia, ax, ay, fill);
    if (typed) begin
      pending_draws.push_back(want);
    end else begin
      foreach (step_draws[i]) pending_draws.push_back(step_draws[i]);
    end
    sent++;
  endtask

  initial begin
    int budget;
    int pick;
    logic [63:0] noise;
    logic [DIA_W-1:0] dia;
    logic [ASPECT_W-1:0] ax;
    logic [ASPECT_W-1:0] ay;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send(plan[i].op, plan[i].cx, plan[i].cy, plan[i].dia, plan[i].ax, plan[i].ay,
           plan[i].fill, plan[i].typed, plan[i].want);
    end

    // Let the block drain completely before the random part.
    in_valid <= 1'b0;
    wait (pending_draws.size() == 0);
    @(posedge clk);

    while (sent < PLAN_LEN + RANDOM_ITEMS) begin
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        dia = 12'hFFF - DIA_W'($urandom_range(0, 1));
      end else if (pick < 15) begin
        dia = DIA_W'($urandom_range(0, 600));
      end else begin
        dia = DIA_W'($urandom_range(0, 24));
      end
      ax = ($urandom_range(0, 3) == 0) ? ASPECT_W'($urandom_range(1, 255))
                                       : ASPECT_W'($urandom_range(1, 12));
      ay = ($urandom_range(0, 3) == 0) ? ASPECT_W'($urandom_range(1, 255))
                                       : ASPECT_W'($urandom_range(1, 12));
      budget = (pick < 3) ? $urandom_range(1, 6) : $urandom_range(20, 150);
      noise  = {$urandom, $urandom};
      send(OP_START, noise[15:0], noise[31:16], dia, ax, ay, noise[60], 1'b0, '0);
      for (int k = 0; k < budget && figure_live; k++) begin
        noise = {$urandom, $urandom};
        send(OP_STEP, noise[15:0], noise[31:16], noise[43:32], noise[51:44],
             noise[59:52], noise[60], 1'b0, '0);
      end
      repeat ($urandom_range(0, 2)) begin
        noise = {$urandom, $urandom};
        send(OP_STEP, noise[15:0], noise[31:16], noise[43:32], noise[51:44],
             noise[59:52], noise[60], 1'b0, '0);
      end
      if ($urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        wait (pending_draws.size() == 0);
        @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    wait (pending_draws.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("axis_aligned_ellipse_stepper test passed");
    end else begin
      $display("axis_aligned_ellipse_stepper test failed");
    end
    $finish;
  end

  initial begin
    int stall;
    draw_t got;
    draw_t want;
    @(posedge rst_n);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind    = kind_e'(out_kind);
      got.left_x  = out_data[COL_W-1:0];
      got.right_x = out_data[2*COL_W-1:COL_W];
      got.row_y   = out_data[2*COL_W+ROW_W-1:2*COL_W];
      got.done    = out_data[2*COL_W+ROW_W];
      got.last    = out_last;
      if (pending_draws.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, got %p", $time, got);
      end else begin
        want = pending_draws.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: transaction mismatch, expected %p, got %p", $time, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("axis_aligned_ellipse_stepper test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
